// ===== rtl/core/uniform_bin_histogram_defines.svh =====
// Assertion macros shared by the histogram RTL.
`ifndef UNIFORM_BIN_HISTOGRAM_DEFINES_SVH
`define UNIFORM_BIN_HISTOGRAM_DEFINES_SVH

// Same-cycle implication check.
`define UBH_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ubh same-cycle check failed");

// Next-cycle implication check.
`define UBH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ubh next-cycle check failed");

`endif

// ===== rtl/core/ubh_pkg.sv =====
// Shared constants and types for the uniform bin histogram.
package ubh_pkg;

   localparam int BINS        = 256;
   localparam int SAMPLE_BITS = 32;
   localparam int BIN_W       = $clog2(BINS);
   // quotient bits: top bit flags a quotient of at least 2**BIN_W
   localparam int Q_W         = BIN_W + 1;
   localparam int STEP_W      = $clog2(Q_W);
   localparam int DW          = ((SAMPLE_BITS > 32) ? SAMPLE_BITS : 32) + 1;
   localparam int CMP_W       = (DW > 32 + BIN_W) ? DW : 32 + BIN_W;
   localparam int NB_W        = (BIN_W + 1 > 9) ? BIN_W + 1 : 9;
   localparam int IDX_W       = 8;
   localparam int CNT_W       = 32;
   // saturation level of the bin counts and the total
   localparam logic [CNT_W-1:0] CNT_MAX = '1;
   localparam int Q_DEPTH     = 2;
   localparam int QP_W        = $clog2(Q_DEPTH);
   localparam int QC_W        = $clog2(Q_DEPTH + 1);

   typedef enum logic [1:0] {
      REG_RANGE_LOW   = 2'd0,
      REG_BIN_WIDTH   = 2'd1,
      REG_BINS_IN_USE = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic signed [31:0] range_low;
      logic [31:0]        bin_width;
      logic [8:0]         bins_in_use;
   } cfg_type;

   // classified request handed from front to back
   typedef struct packed {
      logic             is_read;
      logic             hit;
      logic [BIN_W-1:0] bin;
      logic [IDX_W-1:0] index;
   } op_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_CLASS,
      F_DIV,
      F_FIN,
      F_PUSH
   } front_state_type;

   typedef enum logic {
      B_IDLE,
      B_UPD
   } back_state_type;

endpackage

// ===== rtl/core/ubh_queue.sv =====
// Two-entry queue of classified requests between front and back.
`include "uniform_bin_histogram_defines.svh"

module ubh_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  ubh_pkg::op_type push_op,
   output logic            full,
   input  logic            pop,
   output logic            empty,
   output ubh_pkg::op_type head
);

   ubh_pkg::op_type                entries_ff [ubh_pkg::Q_DEPTH];
   logic [ubh_pkg::QP_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ubh_pkg::QP_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ubh_pkg::QC_W-1:0]       count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

   assign full  = (count_ff == ubh_pkg::QC_W'(ubh_pkg::Q_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   `UBH_ASSERT_IMPLIES(a_no_push_full, clock, reset, push, !full)
   `UBH_ASSERT_IMPLIES(a_no_pop_empty, clock, reset, pop, !empty)

endmodule

// ===== rtl/core/ubh_front.sv =====
// Front end: accepts requests, finds the bin by restoring division, classifies.
module ubh_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ubh_pkg::cfg_type                     cfg,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic signed [ubh_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic [ubh_pkg::IDX_W-1:0]            req_bin_select,
   output logic                                 push,
   output ubh_pkg::op_type                      push_op,
   input  logic                                 full
);

   ubh_pkg::front_state_type            state_ff, state_in;
   logic                                kind_ff, kind_in;
   logic [ubh_pkg::IDX_W-1:0]           sel_ff, sel_in;
   logic signed [ubh_pkg::DW-1:0]       d_ff, d_in;
   logic [ubh_pkg::CMP_W-1:0]           rem_ff, rem_in;
   logic [ubh_pkg::CMP_W-1:0]           div_ff, div_in;
   logic [ubh_pkg::Q_W-1:0]             q_ff, q_in;
   logic [ubh_pkg::STEP_W-1:0]          step_ff, step_in;
   ubh_pkg::op_type                     entry_ff, entry_in;
   logic [ubh_pkg::NB_W-1:0]            nb;
   logic                                ge;
   logic                                trivial;

   // effective bin count: min(bins_in_use, BINS)
   always_comb begin
      if (ubh_pkg::NB_W'(cfg.bins_in_use) < ubh_pkg::NB_W'(ubh_pkg::BINS)) begin
         nb = ubh_pkg::NB_W'(cfg.bins_in_use);
      end else begin
         nb = ubh_pkg::NB_W'(ubh_pkg::BINS);
      end
   end

   assign ge      = (rem_ff >= div_ff);
   // reads, negative offsets and zero width skip the divider
   assign trivial = kind_ff || d_ff[ubh_pkg::DW-1] || (cfg.bin_width == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ubh_pkg::F_IDLE: begin
            if (req_valid) state_in = ubh_pkg::F_CLASS;
         end
         ubh_pkg::F_CLASS: begin
            state_in = trivial ? ubh_pkg::F_PUSH : ubh_pkg::F_DIV;
         end
         ubh_pkg::F_DIV: begin
            if (step_ff == '0) state_in = ubh_pkg::F_FIN;
         end
         ubh_pkg::F_FIN: begin
            state_in = ubh_pkg::F_PUSH;
         end
         ubh_pkg::F_PUSH: begin
            if (!full) state_in = ubh_pkg::F_IDLE;
         end
         default: begin
            state_in = ubh_pkg::F_IDLE;
         end
      endcase
   end

   // handshake outputs
   always_comb begin
      req_ready = (state_ff == ubh_pkg::F_IDLE);
      push      = (state_ff == ubh_pkg::F_PUSH) && !full;
      push_op   = entry_ff;
   end

   // datapath: capture, classify, one quotient bit per cycle
   always_comb begin
      kind_in  = kind_ff;
      sel_in   = sel_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      q_in     = q_ff;
      step_in  = step_ff;
      entry_in = entry_ff;
      case (state_ff)
         ubh_pkg::F_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind;
               sel_in  = req_bin_select;
               d_in    = ubh_pkg::DW'(req_sample) - ubh_pkg::DW'(cfg.range_low);
            end
         end
         ubh_pkg::F_CLASS: begin
            if (kind_ff) begin
               entry_in.is_read = 1'b1;
               entry_in.hit     = (ubh_pkg::NB_W'(sel_ff) < nb);
               entry_in.bin     = ubh_pkg::BIN_W'(sel_ff);
               entry_in.index   = sel_ff;
            end else begin
               entry_in = '0;
               rem_in   = ubh_pkg::CMP_W'(d_ff);
               div_in   = ubh_pkg::CMP_W'(cfg.bin_width) << ubh_pkg::BIN_W;
               q_in     = '0;
               step_in  = ubh_pkg::STEP_W'(ubh_pkg::Q_W - 1);
            end
         end
         ubh_pkg::F_DIV: begin
            rem_in  = ge ? rem_ff - div_ff : rem_ff;
            div_in  = div_ff >> 1;
            q_in    = {q_ff[ubh_pkg::Q_W-2:0], ge};
            step_in = step_ff - 1'b1;
         end
         ubh_pkg::F_FIN: begin
            entry_in.is_read = 1'b0;
            entry_in.hit     = !q_ff[ubh_pkg::Q_W-1] &&
                               (ubh_pkg::NB_W'(q_ff[ubh_pkg::BIN_W-1:0]) < nb);
            entry_in.bin     = q_ff[ubh_pkg::BIN_W-1:0];
            entry_in.index   = entry_in.hit ?
                               ubh_pkg::IDX_W'(q_ff[ubh_pkg::BIN_W-1:0]) : '0;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ubh_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      sel_ff   <= sel_in;
      d_ff     <= d_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      q_ff     <= q_in;
      step_ff  <= step_in;
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/core/ubh_back.sv =====
// Back end: bin count memory, saturating update, total and response register.
`include "uniform_bin_histogram_defines.svh"

module ubh_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        empty,
   input  ubh_pkg::op_type             head,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ubh_pkg::IDX_W-1:0]   rsp_bin_index,
   output logic                        rsp_in_range,
   output logic [ubh_pkg::CNT_W-1:0]   rsp_bin_count,
   output logic [ubh_pkg::CNT_W-1:0]   rsp_total_count
);

   ubh_pkg::back_state_type          state_ff, state_in;
   ubh_pkg::op_type                  op_ff;
   logic [ubh_pkg::CNT_W-1:0]        mem [ubh_pkg::BINS];
   logic [ubh_pkg::BINS-1:0]         valid_ff;
   logic [ubh_pkg::CNT_W-1:0]        rd_data_ff;
   logic                             rd_valid_ff;
   logic [ubh_pkg::CNT_W-1:0]        total_ff, total_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ubh_pkg::IDX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic                             rsp_hit_ff, rsp_hit_in;
   logic [ubh_pkg::CNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic [ubh_pkg::CNT_W-1:0]        rsp_total_ff, rsp_total_in;
   logic [ubh_pkg::CNT_W-1:0]        old_cnt, new_cnt;
   logic                             bump;
   logic                             advance;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ubh_pkg::B_IDLE: begin
            if (!empty) state_in = ubh_pkg::B_UPD;
         end
         ubh_pkg::B_UPD: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ubh_pkg::B_IDLE;
         end
         default: begin
            state_in = ubh_pkg::B_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      pop     = (state_ff == ubh_pkg::B_IDLE) && !empty;
      advance = (state_ff == ubh_pkg::B_UPD) && (!rsp_valid_ff || rsp_ready);
   end

   // saturating count update and response fields
   always_comb begin
      old_cnt = rd_valid_ff ? rd_data_ff : '0;
      bump    = !op_ff.is_read && op_ff.hit;
      new_cnt = (bump && old_cnt != ubh_pkg::CNT_MAX) ? old_cnt + 1'b1 : old_cnt;
      total_in = total_ff;
      if (advance && bump && total_ff != ubh_pkg::CNT_MAX) begin
         total_in = total_ff + 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_count_in = rsp_count_ff;
      rsp_total_in = rsp_total_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = op_ff.index;
         rsp_hit_in   = op_ff.hit;
         rsp_count_in = op_ff.hit ? new_cnt : '0;
         rsp_total_in = total_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ubh_pkg::B_IDLE;
         valid_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance && bump) begin
            valid_ff[op_ff.bin] <= 1'b1;
         end
      end
   end

   // count memory: registered read on pop, write on update
   always_ff @(posedge clock) begin
      if (pop) begin
         op_ff       <= head;
         rd_data_ff  <= mem[head.bin];
         rd_valid_ff <= valid_ff[head.bin];
      end
      if (advance && bump) begin
         mem[op_ff.bin] <= new_cnt;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_count_ff <= rsp_count_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bin_index   = rsp_index_ff;
   assign rsp_in_range    = rsp_hit_ff;
   assign rsp_bin_count   = rsp_count_ff;
   assign rsp_total_count = rsp_total_ff;

   `UBH_ASSERT_IMPLIES(a_miss_zero, clock, reset, rsp_valid && !rsp_in_range, rsp_bin_count == '0)
   `UBH_ASSERT_NEXT(a_total_mono, clock, reset, 1'b1, total_ff >= $past(total_ff))

endmodule

// ===== rtl/core/uniform_bin_histogram.sv =====
// Uniform bin histogram: reads and samples that skip the divider (negative offset, zero width)
// pass capture, classify and push; other samples also pass the one-bit-per-cycle divider and
// a finish step. The front end takes a new request only once it has pushed the last one; the
// back end does a read-modify-write of the count memory per request, and a 2-entry queue
// decouples the two. Synchronous active-high reset clears bin counts (valid bits), total and
// registers (0, 1.0, 256); no clearing pass.
module uniform_bin_histogram (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_kind,
   input  logic signed [ubh_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic [ubh_pkg::IDX_W-1:0]              req_bin_select,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [ubh_pkg::IDX_W-1:0]              rsp_bin_index,
   output logic                                   rsp_in_range,
   output logic [ubh_pkg::CNT_W-1:0]              rsp_bin_count,
   output logic [ubh_pkg::CNT_W-1:0]              rsp_total_count,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [1:0]                             csr_index,
   input  logic [31:0]                            csr_data
);

   ubh_pkg::cfg_type cfg_ff, cfg_in;
   logic             q_push, q_pop, q_full, q_empty;
   ubh_pkg::op_type  q_in_op, q_head;

   // configuration register writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            ubh_pkg::REG_RANGE_LOW:   cfg_in.range_low   = csr_data;
            ubh_pkg::REG_BIN_WIDTH:   cfg_in.bin_width   = csr_data;
            ubh_pkg::REG_BINS_IN_USE: cfg_in.bins_in_use = csr_data[8:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_low   <= '0;
         cfg_ff.bin_width   <= 32'd65536;
         cfg_ff.bins_in_use <= 9'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ubh_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_sample     (req_sample),
      .req_bin_select (req_bin_select),
      .push           (q_push),
      .push_op        (q_in_op),
      .full           (q_full)
   );

   ubh_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (q_in_op),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .head    (q_head)
   );

   ubh_back u_back (
      .clock           (clock),
      .reset           (reset),
      .empty           (q_empty),
      .head            (q_head),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_bin_index   (rsp_bin_index),
      .rsp_in_range    (rsp_in_range),
      .rsp_bin_count   (rsp_bin_count),
      .rsp_total_count (rsp_total_count)
   );

endmodule

// ===== test/tb_uniform_bin_histogram.sv =====
// Self-checking testbench for the uniform bin histogram: directed edge cases, then random phases.
module tb_uniform_bin_histogram;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic        KIND_SAMPLE  = 1'b0;
   localparam logic        KIND_READ    = 1'b1;
   localparam int          NUM_PHASES   = 8;
   localparam int          SETTLE_LEN   = 20;
   localparam int          MAX_REPORTS  = 10;
   localparam logic [31:0] CNT_MAX      = '1;

   typedef struct packed {
      logic [ubh_pkg::IDX_W-1:0] bin_index;
      logic                      in_range;
      logic [ubh_pkg::CNT_W-1:0] bin_count;
      logic [ubh_pkg::CNT_W-1:0] total_count;
   } hist_result_type;

   // shadow copy of the registers and bin counts, plus the queue of pending responses
   class bin_count_tracker;
      logic signed [31:0]        range_low;
      logic [31:0]               bin_width;
      logic [8:0]                bins_in_use;
      logic [ubh_pkg::CNT_W-1:0] counts [ubh_pkg::BINS];
      logic [ubh_pkg::CNT_W-1:0] total;
      hist_result_type           expected_rsp [$];
      int                        errors;

      function new();
         range_low   = '0;
         bin_width   = 32'h0001_0000;
         bins_in_use = 9'd256;
         foreach (counts[i]) counts[i] = '0;
         total  = '0;
         errors = 0;
      endfunction

      function void set_reg(ubh_pkg::reg_index_type idx, logic [31:0] data);
         case (idx)
            ubh_pkg::REG_RANGE_LOW:   range_low   = data;
            ubh_pkg::REG_BIN_WIDTH:   bin_width   = data;
            ubh_pkg::REG_BINS_IN_USE: bins_in_use = data[8:0];
            default: ;
         endcase
      endfunction

      // bin lookup and count update for one accepted request
      function void note_request(logic kind, logic signed [31:0] sample, logic [7:0] sel);
         hist_result_type   r;
         int unsigned       nb;
         longint            diff;
         longint unsigned   quo;
         r  = '0;
         nb = (bins_in_use < ubh_pkg::BINS) ? bins_in_use : ubh_pkg::BINS;
         if (kind == KIND_SAMPLE) begin
            diff = longint'(sample) - longint'(range_low);
            if (diff >= 0 && bin_width != 0) begin
               quo = longint'(diff) / longint'({32'b0, bin_width});
               if (quo < nb) begin
                  if (counts[quo] != CNT_MAX) counts[quo]++;
                  if (total != CNT_MAX) total++;
                  r.bin_index = 8'(quo);
                  r.in_range  = 1'b1;
                  r.bin_count = counts[quo];
               end
            end
         end else begin
            r.bin_index = sel;
            if (sel < nb) begin
               r.in_range  = 1'b1;
               r.bin_count = counts[sel];
            end
         end
         r.total_count = total;
         expected_rsp = {expected_rsp, r};
      endfunction

      function void check_response(hist_result_type got);
         hist_result_type want;
         if (expected_rsp.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: response with nothing pending: index %0d count %0d total %0d",
                        $time, got.bin_index, got.bin_count, got.total_count);
            return;
         end
         want = expected_rsp.pop_front();
         if (got.bin_index !== want.bin_index || got.in_range !== want.in_range ||
             got.bin_count !== want.bin_count || got.total_count !== want.total_count) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("%0t: mismatch exp/got: index %0d/%0d in_range %0b/%0b", $time,
                        want.bin_index, got.bin_index, want.in_range, got.in_range);
               $display("   count %0d/%0d total %0d/%0d",
                        want.bin_count, got.bin_count, want.total_count, got.total_count);
            end
         end
      endfunction
   endclass

   logic                                   clock;
   logic                                   reset;
   logic                                   req_valid;
   logic                                   req_ready;
   logic                                   req_kind;
   logic signed [ubh_pkg::SAMPLE_BITS-1:0] req_sample;
   logic [ubh_pkg::IDX_W-1:0]              req_bin_select;
   logic                                   rsp_valid;
   logic                                   rsp_ready;
   logic [ubh_pkg::IDX_W-1:0]              rsp_bin_index;
   logic                                   rsp_in_range;
   logic [ubh_pkg::CNT_W-1:0]              rsp_bin_count;
   logic [ubh_pkg::CNT_W-1:0]              rsp_total_count;
   logic                                   csr_valid;
   logic                                   csr_ready;
   logic [1:0]                             csr_index;
   logic [31:0]                            csr_data;

   bin_count_tracker tracker = new();
   int req_calm = 0;

   uniform_bin_histogram DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_sample      (req_sample),
      .req_bin_select  (req_bin_select),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_bin_index   (rsp_bin_index),
      .rsp_in_range    (rsp_in_range),
      .rsp_bin_count   (rsp_bin_count),
      .rsp_total_count (rsp_total_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle cycles before the next request; occasional stretches with no idling
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
      return $urandom_range(0, 10);
   endfunction

   // one request; valid stays high afterwards so back-to-back requests need no toggle
   task automatic send_request(logic kind, logic [31:0] sample, logic [7:0] sel);
      int gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_sample     <= sample;
      req_bin_select <= sel;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(kind, sample, sel);
   endtask

   // stop sending and wait until every pending response has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_LEN) @(posedge clock);
   endtask

   // write all three registers back to back
   task automatic write_config(logic [31:0] lo, logic [31:0] bw, logic [8:0] nbins);
      logic [31:0]            vals [3];
      ubh_pkg::reg_index_type idx;
      vals = '{lo, bw, {23'b0, nbins}};
      for (int i = 0; i < 3; i++) begin
         idx = ubh_pkg::reg_index_type'(i);
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         tracker.set_reg(idx, vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   // response side: random stalls, check on every handshake
   initial begin
      int              gap;
      int              calm;
      hist_result_type got;
      calm = 0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(calm);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.bin_index   = rsp_bin_index;
         got.in_range    = rsp_in_range;
         got.bin_count   = rsp_bin_count;
         got.total_count = rsp_total_count;
         tracker.check_response(got);
      end
   end

   // watchdog
   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      logic [31:0]     lo;
      logic [31:0]     bw;
      logic [8:0]      nbins;
      longint unsigned width;
      int unsigned     nb;
      int unsigned     k;
      int unsigned     off;
      int unsigned     pick;
      int              n_items;
      longint          aim;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_kind       <= KIND_SAMPLE;
      req_sample     <= '0;
      req_bin_select <= '0;
      csr_valid      <= 1'b0;
      csr_index      <= ubh_pkg::REG_RANGE_LOW;
      csr_data       <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: unit bins from 0.0, edges of first and last bin
      send_request(KIND_READ,   32'h0, 8'd0);
      send_request(KIND_SAMPLE, 32'h0000_0000, 8'd0);
      send_request(KIND_SAMPLE, 32'h0000_FFFF, 8'd0);
      send_request(KIND_SAMPLE, 32'h0001_0000, 8'd0);
      send_request(KIND_SAMPLE, 32'h00FF_FFFF, 8'd0);
      send_request(KIND_SAMPLE, 32'h0100_0000, 8'd0);
      send_request(KIND_SAMPLE, 32'hFFFF_FFFF, 8'd0);
      send_request(KIND_SAMPLE, 32'h7FFF_FFFF, 8'd0);
      send_request(KIND_SAMPLE, 32'h8000_0000, 8'd0);
      send_request(KIND_READ,   32'h0, 8'd255);
      send_request(KIND_READ,   32'h0, 8'd1);
      settle();

      // lowest edge, widest bin, single bin in use
      write_config(32'h8000_0000, 32'hFFFF_FFFF, 9'd1);
      send_request(KIND_SAMPLE, 32'h8000_0000, 8'd0);
      send_request(KIND_SAMPLE, 32'h7FFF_FFFF, 8'd0);
      send_request(KIND_READ,   32'h0, 8'd0);
      send_request(KIND_READ,   32'h0, 8'd1);
      settle();

      // highest edge, narrowest bin
      write_config(32'h7FFF_FFFF, 32'h0000_0001, 9'd256);
      send_request(KIND_SAMPLE, 32'h7FFF_FFFF, 8'd0);
      send_request(KIND_SAMPLE, 32'h7FFF_FFFE, 8'd0);
      settle();

      // zero width: nothing lands, stored counts are kept
      write_config(32'h0, 32'h0, 9'd256);
      send_request(KIND_SAMPLE, 32'h0, 8'd0);
      send_request(KIND_READ,   32'h0, 8'd0);
      settle();

      // no bins in use
      write_config(32'h0, 32'h0001_0000, 9'd0);
      send_request(KIND_SAMPLE, 32'h0, 8'd0);
      send_request(KIND_READ,   32'h0, 8'd0);
      settle();

      // bin count above the built size is clipped
      write_config(32'h0, 32'h0001_0000, 9'd511);
      send_request(KIND_SAMPLE, 32'h00FF_FFFF, 8'd0);
      send_request(KIND_READ,   32'h0, 8'd255);
      settle();

      // random phases, each with its own register setting
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin lo = 32'h0; bw = 32'h0001_0000; nbins = 9'd256; end
            1: begin lo = 32'h8000_0000; bw = 32'hFFFF_FFFF; nbins = 9'd1; end
            2: begin lo = 32'h7FFF_FFFF; bw = 32'h1; nbins = 9'd256; end
            3: begin
               lo    = -$urandom_range(0, 32'h00FF_FFFF);
               bw    = $urandom_range(1, 32'h00FF_FFFF);
               nbins = 9'($urandom_range(1, 256));
            end
            4: begin lo = $urandom; bw = $urandom_range(1, 32'h0100_0000); nbins = 9'd255; end
            5: begin lo = $urandom; bw = 32'h0; nbins = 9'($urandom_range(1, 256)); end
            6: begin lo = $urandom; bw = $urandom_range(1, 32'h0000_FFFF); nbins = 9'd0; end
            default: begin
               lo    = -$urandom_range(0, 1000);
               bw    = $urandom_range(1, 16);
               nbins = 9'd300;
            end
         endcase
         write_config(lo, bw, nbins);
         n_items = (phase == 5 || phase == 6) ? 100 : 300;
         for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
               send_request(KIND_READ, $urandom, 8'($urandom_range(0, 255)));
            end else if (pick < 40) begin
               send_request(KIND_SAMPLE, $urandom, 8'($urandom));
            end else begin
               // aim at a bin edge or inside a bin, including just past the last one
               width = (tracker.bin_width == 0) ? 1 : tracker.bin_width;
               nb    = (tracker.bins_in_use > ubh_pkg::BINS) ? ubh_pkg::BINS :
                       tracker.bins_in_use;
               k     = $urandom_range(0, nb + 1);
               case ($urandom_range(0, 3))
                  0:       off = 0;
                  1:       off = 32'(width - 1);
                  default: off = $urandom_range(0, 32'(width - 1));
               endcase
               aim = longint'(tracker.range_low) + longint'(k) * longint'(width) +
                     longint'(off);
               send_request(KIND_SAMPLE, 32'(aim), 8'($urandom));
            end
         end
         // hold off until the histogram has caught up before the next setting
         settle();
      end

      if (tracker.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
